FILE: hw/rtl/ulsf_pkg.sv
// Shared types, constants and helpers for the UTF-16 lone-surrogate repair block.
package ulsf_pkg;

	localparam int LANES  = 4;
	localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int CNT_W  = 3;
	localparam int DEPTH  = 4;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int QCNT_W = $clog2(DEPTH + 1);
	localparam int ADDR_W = 3;

	localparam logic [15:0] TAG_MASK = 16'hfc00;
	localparam logic [15:0] HI_TAG   = 16'hd800;
	localparam logic [15:0] LO_TAG   = 16'hdc00;
	localparam logic [15:0] REPL_LE  = 16'hfffd;
	localparam logic [15:0] REPL_BE  = 16'hfdff;

	// Register index within the configuration space
	typedef enum logic [0:0] {
		REG_BYTE_SWAP = 1'b0,
		REG_NONE      = 1'b1
	} reg_idx_t;

	typedef logic [LANES-1:0][15:0] unit_vec_t;

	typedef struct packed {
		logic [15:0]      unit_0;
		logic [15:0]      unit_1;
		logic [15:0]      unit_2;
		logic [15:0]      unit_3;
		logic [CNT_W-1:0] unit_count;
		logic             stream_end;
	} in_word_t;

	typedef struct packed {
		logic [15:0]      fixed_0;
		logic [15:0]      fixed_1;
		logic [15:0]      fixed_2;
		logic [15:0]      fixed_3;
		logic [CNT_W-1:0] fixed_count;
		logic             is_last;
	} out_word_t;

	// Surrogate class of one unit
	typedef struct packed {
		logic hi;
		logic lo;
	} class_t;

	// One classified group on its way to the merge stage
	typedef struct packed {
		unit_vec_t        units;
		logic [LANES-1:0] hi;
		logic [LANES-1:0] lo;
		logic [CNT_W-1:0] cnt;
		logic             last;
	} grp_t;

	// Write strobes into the result queue
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

	function automatic logic [15:0] swap16(input logic [15:0] w);
		return {w[7:0], w[15:8]};
	endfunction

	function automatic logic [15:0] repl_word(input logic be);
		return be ? REPL_BE : REPL_LE;
	endfunction

	// Build one result word: replace flagged units, zero unused lanes
	function automatic out_word_t make_word(input unit_vec_t u, input logic [CNT_W-1:0] cnt,
			input logic [LANES-1:0] mask, input logic be, input logic last);
		unit_vec_t f;
		out_word_t w;
		for (int i = 0; i < LANES; i++) begin
			if (CNT_W'(i) < cnt) begin
				f[i] = mask[i] ? repl_word(be) : u[i];
			end else begin
				f[i] = '0;
			end
		end
		w.fixed_0     = f[0];
		w.fixed_1     = f[1];
		w.fixed_2     = f[2];
		w.fixed_3     = f[3];
		w.fixed_count = cnt;
		w.is_last     = last;
		return w;
	endfunction

endpackage

FILE: hw/rtl/utf16_lone_surrogate_fix.sv
// Top level: UTF-16 lone-surrogate repair, four code units per word.
//
// Input channel (item_valid / item_stall / item): one group of up to four
// code units a word, unit_count valid from lane 0, stream_end on the last.
// Output channel (result_valid / result_stall / result): the same units with
// each unpaired surrogate replaced by U+FFFD (FDFF when byte swap is set).
// Throughput: one input word per cycle while item_stall is low. A group
// is held until the next group arrives, since its last unit is judged by
// the next group's first unit; it is released into the queue when that
// group reaches the merge stage. A final group (stream_end) is queued
// behind any held group released with it, so an end group may give two
// result words together. The lane flags sit one register stage before
// the merge stage; a four-entry result queue decouples the output from
// the input and keeps the input moving while a result waits.
// When result_stall is high the queue fills; the input stalls once fewer
// than two queue entries are free and the lane stage holds a group.
// Reset clears the held group, the queue and the byte-swap bit.
// The byte-swap bit is at APB byte address 0, bit 0; pready is always high.
module utf16_lone_surrogate_fix (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  ulsf_pkg::in_word_t           item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output ulsf_pkg::out_word_t          result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ulsf_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic                        be_q;
	ulsf_pkg::reg_idx_t          reg_idx;
	ulsf_pkg::unit_vec_t         item_units;
	logic [ulsf_pkg::CNT_W-1:0]  cnt_in;
	ulsf_pkg::class_t            lane_cls [ulsf_pkg::LANES];
	ulsf_pkg::grp_t              grp_in;
	ulsf_pkg::grp_t              grp_s1;
	logic                        valid_s1;
	logic                        adv;
	logic                        room;
	ulsf_pkg::push_t             push;
	ulsf_pkg::out_word_t         word_0;
	ulsf_pkg::out_word_t         word_1;

	// Register decode
	assign pready  = 1'b1;
	assign reg_idx = ulsf_pkg::reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (reg_idx)
			ulsf_pkg::REG_BYTE_SWAP: prdata = {31'b0, be_q};
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			be_q <= 1'b0;
		end else if (psel && penable && pwrite && (reg_idx == ulsf_pkg::REG_BYTE_SWAP)) begin
			be_q <= pwdata[0];
		end
	end

	// Unpack the word and clamp the count to the lane count
	always_comb begin
		item_units[0] = item.unit_0;
		item_units[1] = item.unit_1;
		item_units[2] = item.unit_2;
		item_units[3] = item.unit_3;
		cnt_in = (item.unit_count > ulsf_pkg::CNT_W'(ulsf_pkg::LANES))
			? ulsf_pkg::CNT_W'(ulsf_pkg::LANES) : item.unit_count;
	end

	// Classify each lane side by side
	for (genvar g = 0; g < ulsf_pkg::LANES; g++) begin : g_lane
		ulsf_lane u_lane (
			.unit (item_units[g]),
			.be   (be_q),
			.used (ulsf_pkg::CNT_W'(g) < cnt_in),
			.cls  (lane_cls[g])
		);
	end

	always_comb begin
		for (int i = 0; i < ulsf_pkg::LANES; i++) begin
			grp_in.units[i] = (ulsf_pkg::CNT_W'(i) < cnt_in) ? item_units[i] : 16'h0;
			grp_in.hi[i]    = lane_cls[i].hi;
			grp_in.lo[i]    = lane_cls[i].lo;
		end
		grp_in.cnt  = cnt_in;
		grp_in.last = item.stream_end;
	end

	// Advance the lane stage whenever the merge stage can take its group
	assign adv        = !valid_s1 || room;
	assign item_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_valid) begin
			grp_s1 <= grp_in;
		end
	end

	ulsf_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.be        (be_q),
		.grp_valid (valid_s1),
		.grp       (grp_s1),
		.room      (room),
		.push      (push),
		.word_0    (word_0),
		.word_1    (word_1)
	);

	ulsf_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.word_0       (word_0),
		.word_1       (word_1),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: hw/rtl/ulsf_lane.sv
// One lane: classifies a code unit as high or low surrogate.
module ulsf_lane (
	input  logic [15:0]     unit,
	input  logic            be,
	input  logic            used,
	output ulsf_pkg::class_t cls
);

	logic [15:0] norm;

	// Undo byte order, then match the surrogate tag
	always_comb begin
		norm   = be ? ulsf_pkg::swap16(unit) : unit;
		cls.hi = used && ((norm & ulsf_pkg::TAG_MASK) == ulsf_pkg::HI_TAG);
		cls.lo = used && ((norm & ulsf_pkg::TAG_MASK) == ulsf_pkg::LO_TAG);
	end

endmodule

FILE: hw/rtl/ulsf_merge.sv
// Merge stage: joins lane flags, holds one group back and forms results.
module ulsf_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                be,
	input  logic                grp_valid,
	input  ulsf_pkg::grp_t      grp,
	input  logic                room,
	output ulsf_pkg::push_t     push,
	output ulsf_pkg::out_word_t word_0,
	output ulsf_pkg::out_word_t word_1
);

	ulsf_pkg::unit_vec_t                 held_units_q;
	logic [ulsf_pkg::LANES-1:0]          held_mask_q;
	logic [ulsf_pkg::CNT_W-1:0]          held_cnt_q;
	logic                                held_valid_q;

	logic                                go;
	logic                                cnt_zero;
	logic [ulsf_pkg::LANE_W-1:0]         hl;
	logic [ulsf_pkg::LANE_W-1:0]         cl;
	ulsf_pkg::class_t                    held_cls;
	logic [ulsf_pkg::LANES-1:0]          cur_mask;
	logic [ulsf_pkg::LANES-1:0]          rel_mask;
	logic                                rel;
	logic                                cur_emit;
	ulsf_pkg::out_word_t                 held_word;
	ulsf_pkg::out_word_t                 cur_word;

	assign go       = grp_valid && room;
	assign cnt_zero = (grp.cnt == '0);
	assign hl       = ulsf_pkg::LANE_W'(held_cnt_q - 1'b1);
	assign cl       = ulsf_pkg::LANE_W'(grp.cnt - 1'b1);

	// Reclassify the held last unit under the current byte order
	ulsf_lane u_held_lane (
		.unit (held_units_q[hl]),
		.be   (be),
		.used (held_valid_q),
		.cls  (held_cls)
	);

	// Decide replacements within the current group
	always_comb begin
		cur_mask    = '0;
		cur_mask[0] = grp.lo[0] && !(held_valid_q && held_cls.hi);
		for (int i = 1; i < ulsf_pkg::LANES; i++) begin
			cur_mask[i] = grp.lo[i] && !grp.hi[i-1];
		end
		for (int i = 0; i < ulsf_pkg::LANES - 1; i++) begin
			if ((ulsf_pkg::CNT_W'(i + 1) < grp.cnt) && grp.hi[i] && !grp.lo[i+1]) begin
				cur_mask[i] = 1'b1;
			end
		end
		if (grp.last && !cnt_zero && grp.hi[cl]) begin
			cur_mask[cl] = 1'b1;
		end
	end

	// Finish the held group against the new group's first unit or the stream end
	always_comb begin
		rel_mask = held_mask_q;
		if (held_cls.hi && (cnt_zero || !grp.lo[0])) begin
			rel_mask[hl] = 1'b1;
		end
		rel       = held_valid_q && (!cnt_zero || grp.last);
		cur_emit  = !cnt_zero && grp.last;
		held_word = ulsf_pkg::make_word(held_units_q, held_cnt_q, rel_mask, be, cnt_zero);
		cur_word  = ulsf_pkg::make_word(grp.units, grp.cnt, cur_mask, be, 1'b1);
	end

	// Released group first, final group second
	always_comb begin
		push.first  = go && (rel || cur_emit);
		push.second = go && rel && cur_emit;
		word_0      = rel ? held_word : cur_word;
		word_1      = cur_word;
	end

	// Hold or drop the group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_cnt_q   <= '0;
			held_mask_q  <= '0;
		end else if (go) begin
			if (grp.last) begin
				held_valid_q <= 1'b0;
			end else if (!cnt_zero) begin
				held_valid_q <= 1'b1;
				held_cnt_q   <= grp.cnt;
				held_mask_q  <= cur_mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && !grp.last && !cnt_zero) begin
			held_units_q <= grp.units;
		end
	end

`ifndef SYNTHESIS
	a_held_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> (held_cnt_q != '0))
		else $error("held group has no units");
	a_end_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(go && grp.last) |=> !held_valid_q)
		else $error("group still held after stream end");
`endif

endmodule

FILE: hw/rtl/ulsf_outq.sv
// Result queue: takes up to two words a cycle, hands out one when result_stall is low.
module ulsf_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  ulsf_pkg::push_t     push,
	input  ulsf_pkg::out_word_t word_0,
	input  ulsf_pkg::out_word_t word_1,
	output logic                room,
	output logic                result_valid,
	input  logic                result_stall,
	output ulsf_pkg::out_word_t result
);

	ulsf_pkg::out_word_t         mem_q [ulsf_pkg::DEPTH];
	logic [ulsf_pkg::PTR_W-1:0]  wr_ptr_q;
	logic [ulsf_pkg::PTR_W-1:0]  rd_ptr_q;
	logic [ulsf_pkg::QCNT_W-1:0] count_q;
	logic                        pop;
	logic [ulsf_pkg::QCNT_W-1:0] n_push;

	assign result_valid = (count_q != '0);
	assign result       = mem_q[rd_ptr_q];
	assign pop          = result_valid && !result_stall;
	assign room         = (count_q <= ulsf_pkg::QCNT_W'(ulsf_pkg::DEPTH - 2));
	assign n_push       = ulsf_pkg::QCNT_W'(push.first) + ulsf_pkg::QCNT_W'(push.second);

	// Store incoming words
	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_ptr_q] <= word_0;
		end
		if (push.second) begin
			mem_q[wr_ptr_q + 1'b1] <= word_1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ulsf_pkg::PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + n_push - ulsf_pkg::QCNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ulsf_pkg::QCNT_W'(ulsf_pkg::DEPTH))
		else $error("result queue over depth");
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.second |-> push.first)
		else $error("second word pushed without first");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.first || push.second) |-> room)
		else $error("push without room");
`endif

endmodule
